>>> hdl/vfv_pkg.sv
// -----------------------------------------------------------------------------
// vfv_pkg
// shared widths, codes and helpers for the voxel face visibility core
// -----------------------------------------------------------------------------
package vfv_pkg;

   localparam int COORD_W      = 5;
   localparam int TYPE_W       = 8;
   localparam int EDGE_W       = 6;
   localparam int MASK_W       = 6;
   localparam int MAX_EDGE_DEF = 32;

   localparam logic [EDGE_W-1:0] EDGE_RESET = 6'd16;
   localparam logic [TYPE_W-1:0] AIR_TYPE   = 8'd0;
   localparam logic [TYPE_W-1:0] EMPTY_TYPE = 8'd6;
   localparam logic [MASK_W-1:0] FULL_MASK  = 6'd63;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic              inside_res;
      logic [MASK_W-1:0] neighbour_mask;
      logic [TYPE_W-1:0] voxel_type;
      logic              draw_cube;
   } rsp_type;

   // air and the see-through type do not cover a face
   function automatic logic is_solid(input logic [TYPE_W-1:0] t);
      return (t != AIR_TYPE) && (t != EMPTY_TYPE);
   endfunction

endpackage

>>> hdl/vfv_if.sv
// -----------------------------------------------------------------------------
// vfv channel interfaces
// request, response and register write channels with valid/ready
// -----------------------------------------------------------------------------
interface vfv_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [vfv_pkg::COORD_W-1:0] coord_x;
   logic [vfv_pkg::COORD_W-1:0] coord_y;
   logic [vfv_pkg::COORD_W-1:0] coord_z;
   logic [vfv_pkg::TYPE_W-1:0]  write_type;

   modport source (output valid, command, coord_x, coord_y, coord_z, write_type,
                   input ready);
   modport sink (input valid, command, coord_x, coord_y, coord_z, write_type,
                 output ready);
endinterface

interface vfv_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       inside_res;
   logic [vfv_pkg::MASK_W-1:0] neighbour_mask;
   logic [vfv_pkg::TYPE_W-1:0] voxel_type;
   logic                       draw_cube;

   modport source (output valid, inside_res, neighbour_mask, voxel_type, draw_cube,
                   input ready);
   modport sink (input valid, inside_res, neighbour_mask, voxel_type, draw_cube,
                 output ready);
endinterface

interface vfv_csr_if;
   logic                       valid;
   logic                       ready;
   logic [vfv_pkg::EDGE_W-1:0] edge_length;

   modport source (output valid, edge_length, input ready);
   modport sink (input valid, edge_length, output ready);
endinterface

>>> hdl/vfv_store.sv
// -----------------------------------------------------------------------------
// vfv_store
// single-port voxel type memory, one access per cycle, registered read data
// -----------------------------------------------------------------------------
module vfv_store #(
   parameter int ADDR_W = 15
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [ADDR_W-1:0]          addr,
   input  logic [vfv_pkg::TYPE_W-1:0] wdata,
   output logic [vfv_pkg::TYPE_W-1:0] rdata
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [vfv_pkg::TYPE_W-1:0] mem [DEPTH];
   logic [vfv_pkg::TYPE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/vfv_seq.sv
// -----------------------------------------------------------------------------
// vfv_seq
// access sequencer: clearing pass, voxel writes, seven-read neighbour query
// -----------------------------------------------------------------------------
module vfv_seq #(
   parameter int MAX_EDGE = vfv_pkg::MAX_EDGE_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [vfv_pkg::EDGE_W-1:0]                eff_edge,
   vfv_req_if.sink                                   req,
   vfv_rsp_if.source                                 rsp,
   output logic                                      mem_we,
   output logic [3*$clog2(MAX_EDGE)-1:0]             mem_addr,
   output logic [vfv_pkg::TYPE_W-1:0]                mem_wdata,
   input  logic [vfv_pkg::TYPE_W-1:0]                mem_rdata
);

   localparam int CW     = $clog2(MAX_EDGE);
   localparam int ADDR_W = 3 * CW;
   localparam int CX_W   = vfv_pkg::EDGE_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [2:0] STEP_FIRST = 3'd1;
   localparam logic [2:0] STEP_MASK0 = 3'd2;
   localparam logic [2:0] STEP_LAST  = 3'd7;

   logic [1:0]                        state_ff, state_in;
   logic [2:0]                        step_ff, step_in;
   logic [ADDR_W-1:0]                 clr_ff, clr_in;
   logic [vfv_pkg::COORD_W-1:0]       x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [vfv_pkg::TYPE_W-1:0]        type_ff, type_in;
   logic [vfv_pkg::MASK_W-1:0]        mask_ff, mask_in;
   logic                              live_ff, live_in;
   vfv_pkg::rsp_type                  res_ff, res_in;
   vfv_pkg::rsp_type                  rsp_ff, rsp_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic                              accept;
   logic                              out_free;
   logic                              in_inside;
   logic [CX_W-1:0]                   in_x, in_y, in_z;
   logic [CX_W-1:0]                   cx, cy, cz, ax, ay, az, c_sel, c_nb;
   logic [2:0]                        nb_idx;
   logic                              nb_ok;
   logic                              rd_issue;
   logic                              hit;
   vfv_pkg::rsp_type                  fin;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign in_x      = CX_W'(req.coord_x);
   assign in_y      = CX_W'(req.coord_y);
   assign in_z      = CX_W'(req.coord_z);
   assign in_inside = (in_x < eff_edge) && (in_y < eff_edge) && (in_z < eff_edge);

   assign cx = CX_W'(x_ff);
   assign cy = CX_W'(y_ff);
   assign cz = CX_W'(z_ff);

   // neighbour order per step: +x -x +y -y +z -z
   always_comb begin
      nb_idx = step_ff - STEP_FIRST;
      case (nb_idx[2:1])
         2'd0:    c_sel = cx;
         2'd1:    c_sel = cy;
         default: c_sel = cz;
      endcase
      if (nb_idx[0]) begin
         c_nb  = c_sel - CX_W'(1);
         nb_ok = (c_sel != '0);
      end else begin
         c_nb  = c_sel + CX_W'(1);
         nb_ok = (c_nb < eff_edge);
      end
      ax = cx;
      ay = cy;
      az = cz;
      case (nb_idx[2:1])
         2'd0:    ax = c_nb;
         2'd1:    ay = c_nb;
         default: az = c_nb;
      endcase
   end

   assign rd_issue = (state_ff == ST_READ) && (step_ff != STEP_LAST) && nb_ok;

   always_comb begin
      case (state_ff)
         ST_CLEAR: mem_addr = clr_ff;
         ST_IDLE:  mem_addr = {in_x[CW-1:0], in_y[CW-1:0], in_z[CW-1:0]};
         default:  mem_addr = {ax[CW-1:0], ay[CW-1:0], az[CW-1:0]};
      endcase
   end

   assign mem_we    = (state_ff == ST_CLEAR)
                   || (accept && (req.command == vfv_pkg::CMD_WRITE) && in_inside);
   assign mem_wdata = (state_ff == ST_CLEAR) ? vfv_pkg::AIR_TYPE : req.write_type;

   assign hit = live_ff && vfv_pkg::is_solid(mem_rdata);

   always_comb begin
      mask_in = mask_ff;
      if (state_ff == ST_READ && step_ff >= STEP_MASK0) begin
         mask_in = mask_ff | (vfv_pkg::MASK_W'(hit) << (step_ff - STEP_MASK0));
      end
      fin.inside_res     = 1'b1;
      fin.neighbour_mask = mask_in;
      fin.voxel_type     = type_ff;
      fin.draw_cube      = (type_ff inside {[8'd1:8'd5]}) && (mask_in != vfv_pkg::FULL_MASK);
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      type_in      = type_ff;
      live_in      = rd_issue;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               x_in = req.coord_x;
               y_in = req.coord_y;
               z_in = req.coord_z;
               if (req.command == vfv_pkg::CMD_QUERY && in_inside) begin
                  state_in = ST_READ;
                  step_in  = STEP_FIRST;
               end else begin
                  res_in.inside_res     = in_inside;
                  res_in.neighbour_mask = '0;
                  res_in.voxel_type     = vfv_pkg::AIR_TYPE;
                  res_in.draw_cube      = 1'b0;
                  state_in              = ST_DONE;
               end
            end
         end
         ST_READ: begin
            step_in = step_ff + 3'd1;
            // centre voxel read was issued in the accept cycle
            if (step_ff == STEP_FIRST) begin
               type_in = mem_rdata;
            end
            if (step_ff == STEP_LAST) begin
               if (out_free) begin
                  rsp_in       = fin;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  res_in   = fin;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= STEP_FIRST;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      type_ff <= type_in;
      mask_ff <= (state_ff == ST_IDLE) ? '0 : mask_in;
      live_ff <= live_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.inside_res     = rsp_ff.inside_res;
   assign rsp.neighbour_mask = rsp_ff.neighbour_mask;
   assign rsp.voxel_type     = rsp_ff.voxel_type;
   assign rsp.draw_cube      = rsp_ff.draw_cube;

   a_we_state : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_IDLE))
      else $error("store written outside clearing pass or accept cycle");

   a_query_start : assert property (@(posedge clock) disable iff (reset)
      (accept && req.command == vfv_pkg::CMD_QUERY && in_inside)
      |=> (state_ff == ST_READ && step_ff == STEP_FIRST))
      else $error("inside query did not start its read sequence");

   a_step_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (step_ff >= STEP_FIRST))
      else $error("read step out of range");

   a_clear_end : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_ff == '1) |=> (state_ff == ST_IDLE))
      else $error("clearing pass did not end");

   a_fin_load : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && step_ff == STEP_LAST && out_free) |=> rsp_valid_ff)
      else $error("finished query not presented");

endmodule

>>> hdl/voxel_face_visibility_core.sv
// -----------------------------------------------------------------------------
// voxel_face_visibility_core
// six-neighbour face culling over a cubic voxel type store
// -----------------------------------------------------------------------------
// After reset the core runs a clearing pass that writes air into every store
// entry, one per cycle; no request is taken meanwhile, register writes are. All
// voxel accesses go through one single-port memory with a registered read, so
// a query inside the chunk reads the voxel itself and then those of its six
// neighbours that lie inside the chunk, one after another, before the next
// accept. A write, or any item outside the chunk, passes through the done
// state before the next accept. One response is given per request, through an
// output register, so the next request may be accepted while a response still
// waits.
// -----------------------------------------------------------------------------
module voxel_face_visibility_core #(
   parameter int MAX_EDGE = vfv_pkg::MAX_EDGE_DEF
) (
   input  logic      clock,
   input  logic      reset,
   vfv_req_if.sink   req_chan,
   vfv_rsp_if.source rsp_chan,
   vfv_csr_if.sink   csr_chan
);

   localparam int ADDR_W = 3 * $clog2(MAX_EDGE);

   logic [vfv_pkg::EDGE_W-1:0] edge_ff, edge_in;
   logic [vfv_pkg::EDGE_W-1:0] eff_edge;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_addr;
   logic [vfv_pkg::TYPE_W-1:0] mem_wdata;
   logic [vfv_pkg::TYPE_W-1:0] mem_rdata;

   assign csr_chan.ready = 1'b1;
   assign edge_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.edge_length : edge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= vfv_pkg::EDGE_RESET;
      end else begin
         edge_ff <= edge_in;
      end
   end

   // an edge above the store size acts as the store size
   assign eff_edge = ({1'b0, edge_ff} > (vfv_pkg::EDGE_W + 1)'(MAX_EDGE))
                   ? vfv_pkg::EDGE_W'(MAX_EDGE) : edge_ff;

   vfv_seq #(
      .MAX_EDGE (MAX_EDGE)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .eff_edge  (eff_edge),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   vfv_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule

>>> tb/vfv_visibility_check.sv
// -----------------------------------------------------------------------------
// vfv_visibility_check
// watches the request, response and register channels of the face visibility
// core, keeps its own copy of the voxel store and edge register, predicts each
// response and compares it field by field in transfer order
// -----------------------------------------------------------------------------
module vfv_visibility_check #(
   parameter int MAX_EDGE = vfv_pkg::MAX_EDGE_DEF
) (
   input  logic clock,
   input  logic reset,
   vfv_req_if   req_mon,
   vfv_rsp_if   rsp_mon,
   vfv_csr_if   csr_mon,
   output int   errors,
   output int   outstanding,
   output int   drawn,
   output int   enclosed
);
   timeunit 1ns;
   timeprecision 1ps;

   import vfv_pkg::*;

   localparam int CELLS = MAX_EDGE * MAX_EDGE * MAX_EDGE;

   logic [TYPE_W-1:0] shadow_types [CELLS];
   logic [EDGE_W-1:0] edge_reg;
   rsp_type           expected_views [$];

   // edge values past the store size behave as the full size
   function automatic int live_edge();
      return (edge_reg > MAX_EDGE) ? MAX_EDGE : int'(edge_reg);
   endfunction

   function automatic int cell_index(int x, int y, int z);
      return (x * MAX_EDGE + y) * MAX_EDGE + z;
   endfunction

   // a neighbour beyond the chunk never covers a face
   function automatic logic covers(int x, int y, int z, int e);
      logic [TYPE_W-1:0] t;
      if (x < 0 || y < 0 || z < 0 || x >= e || y >= e || z >= e) return 1'b0;
      t = shadow_types[cell_index(x, y, z)];
      return (t != AIR_TYPE) && (t != EMPTY_TYPE);
   endfunction

   function automatic rsp_type resolve_visibility(logic cmd, int x, int y, int z,
                                                  logic [TYPE_W-1:0] wt);
      rsp_type           v;
      logic [MASK_W-1:0] mask;
      logic [TYPE_W-1:0] t;
      int                e;
      e = live_edge();
      v = '0;
      if (x < e && y < e && z < e) begin
         v.inside_res = 1'b1;
         if (cmd == CMD_WRITE) begin
            shadow_types[cell_index(x, y, z)] = wt;
         end else begin
            mask[0] = covers(x + 1, y, z, e);
            mask[1] = covers(x - 1, y, z, e);
            mask[2] = covers(x, y + 1, z, e);
            mask[3] = covers(x, y - 1, z, e);
            mask[4] = covers(x, y, z + 1, e);
            mask[5] = covers(x, y, z - 1, e);
            t = shadow_types[cell_index(x, y, z)];
            v.neighbour_mask = mask;
            v.voxel_type     = t;
            v.draw_cube      = (t >= 8'd1) && (t <= 8'd5) && (mask != FULL_MASK);
         end
      end
      return v;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         foreach (shadow_types[i]) shadow_types[i] = AIR_TYPE;
         edge_reg = EDGE_RESET;
         expected_views.delete();
         outstanding <= 0;
      end else begin
         // older responses first, so a transfer on both channels stays ordered
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_views.size() == 0) begin
               errors++;
               $error("response transfer with nothing expected");
            end else begin
               want = expected_views.pop_front();
               check_field("inside_res", want.inside_res, rsp_mon.inside_res);
               check_field("neighbour_mask", want.neighbour_mask, rsp_mon.neighbour_mask);
               check_field("voxel_type", want.voxel_type, rsp_mon.voxel_type);
               check_field("draw_cube", want.draw_cube, rsp_mon.draw_cube);
               if (want.draw_cube) drawn++;
               if (want.inside_res && want.neighbour_mask == FULL_MASK) enclosed++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_views.insert(expected_views.size(), resolve_visibility(
               req_mon.command, req_mon.coord_x, req_mon.coord_y, req_mon.coord_z,
               req_mon.write_type));
         end
         // a register transfer only affects items taken after this edge
         if (csr_mon.valid && csr_mon.ready) edge_reg = csr_mon.edge_length;
         outstanding <= expected_views.size();
      end
   end

endmodule

>>> tb/tb.sv
// -----------------------------------------------------------------------------
// tb
// regression for voxel_face_visibility_core: directed face culling cases, then
// random write/query traffic clustered in small windows over a range of edge
// settings, with bursty requests and a stalling response side
// -----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vfv_pkg::*;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_SPARSE, STALL_LIGHT} stall_kind_e;

   localparam int PHASE_ITEMS = 112;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vfv_req_if req_if ();
   vfv_rsp_if rsp_if ();
   vfv_csr_if csr_if ();

   int          chk_errors;
   int          chk_outstanding;
   int          chk_drawn;
   int          chk_enclosed;
   int          burst_left;
   int          n_writes;
   int          n_queries;
   int          n_edges;
   int          win_lo;
   int          win_w;
   stall_kind_e stall_mode = STALL_NONE;
   int          stall_left;

   always #2 clock = ~clock;

   voxel_face_visibility_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   vfv_visibility_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_mon     (csr_if),
      .errors      (chk_errors),
      .outstanding (chk_outstanding),
      .drawn       (chk_drawn),
      .enclosed    (chk_enclosed)
   );

   // response side stalls in one of four modes, picked anew at random
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_kind_e'($urandom_range(STALL_NONE, STALL_LIGHT));
         stall_left <= $urandom_range(30, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:   rsp_if.ready <= 1'b1;
         STALL_HALF:   rsp_if.ready <= $urandom_range(0, 1);
         STALL_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   task automatic send_item(logic cmd, int x, int y, int z, int wt);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.coord_x    <= x[COORD_W-1:0];
      req_if.coord_y    <= y[COORD_W-1:0];
      req_if.coord_z    <= z[COORD_W-1:0];
      req_if.write_type <= wt[TYPE_W-1:0];
      do @(posedge clock); while (!req_if.ready);
      if (cmd == CMD_WRITE) n_writes++;
      else n_queries++;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (chk_outstanding != 0);
   endtask

   task automatic write_edge(int e);
      csr_if.valid       <= 1'b1;
      csr_if.edge_length <= e[EDGE_W-1:0];
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      n_edges++;
   endtask

   // small window of coordinates so that neighbours are often occupied
   task automatic pick_window(int e);
      int eff;
      eff    = (e > MAX_EDGE_DEF) ? MAX_EDGE_DEF : e;
      win_w  = (eff < 4) ? eff : 4;
      win_lo = (eff == 0) ? 0 : $urandom_range(0, eff - win_w);
   endtask

   function automatic int pick_coord();
      if (win_w == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, 31);
      return win_lo + $urandom_range(0, win_w - 1);
   endfunction

   function automatic int pick_type();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 6) return $urandom_range(1, 7);
      if (r == 7) return AIR_TYPE;
      return $urandom_range(0, 255);
   endfunction

   initial begin : stimulus
      int   edge_plan [$];
      int   spin;
      logic cmd;
      req_if.valid       <= 1'b0;
      req_if.command     <= CMD_WRITE;
      req_if.coord_x     <= '0;
      req_if.coord_y     <= '0;
      req_if.coord_z     <= '0;
      req_if.write_type  <= AIR_TYPE;
      csr_if.valid       <= 1'b0;
      csr_if.edge_length <= EDGE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed cases at the reset edge of 16
      send_item(CMD_QUERY, 0, 0, 0, 8'hff);
      send_item(CMD_WRITE, 1, 1, 1, 3);
      send_item(CMD_WRITE, 2, 1, 1, 1);
      send_item(CMD_WRITE, 0, 1, 1, 2);
      send_item(CMD_WRITE, 1, 2, 1, 4);
      send_item(CMD_WRITE, 1, 0, 1, 5);
      send_item(CMD_WRITE, 1, 1, 2, 200);
      send_item(CMD_WRITE, 1, 1, 0, 255);
      send_item(CMD_QUERY, 1, 1, 1, 0);
      // see-through type uncovers the +z face
      send_item(CMD_WRITE, 1, 1, 2, EMPTY_TYPE);
      send_item(CMD_QUERY, 1, 1, 1, 0);
      send_item(CMD_WRITE, 1, 1, 0, AIR_TYPE);
      send_item(CMD_QUERY, 1, 1, 1, 0);
      // neighbours past either end of the chunk stay empty
      send_item(CMD_QUERY, 0, 1, 1, 0);
      send_item(CMD_WRITE, 15, 15, 15, 5);
      send_item(CMD_WRITE, 15, 15, 14, 7);
      send_item(CMD_QUERY, 15, 15, 15, 0);
      send_item(CMD_WRITE, 16, 3, 3, 9);
      send_item(CMD_QUERY, 3, 16, 3, 0);
      send_item(CMD_QUERY, 31, 31, 31, 8'hff);
      send_item(CMD_WRITE, 1, 1, 1, EMPTY_TYPE);
      send_item(CMD_QUERY, 1, 1, 1, 0);

      edge_plan = '{1, 2, 3, 4, 0, 5, 8, 32, 63, 33};
      repeat (6) edge_plan.insert(edge_plan.size(), $urandom_range(0, 63));
      foreach (edge_plan[p]) begin
         wait_idle();
         write_edge(edge_plan[p]);
         pick_window(edge_plan[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 39) pick_window(edge_plan[p]);
            if (p == 7 && i == PHASE_ITEMS / 2) wait_idle();
            cmd = ($urandom_range(0, 99) < 55) ? CMD_WRITE : CMD_QUERY;
            send_item(cmd, pick_coord(), pick_coord(), pick_coord(),
                      (cmd == CMD_WRITE) ? pick_type() : $urandom_range(0, 255));
         end
      end

      req_if.valid <= 1'b0;
      spin = 0;
      do begin
         @(posedge clock);
         spin++;
      end while (chk_outstanding != 0 && spin < 5000);
      repeat (16) @(posedge clock);
      if (chk_outstanding != 0) $error("%0d responses never arrived", chk_outstanding);

      $display("checked %0d writes and %0d queries across %0d edge settings",
               n_writes, n_queries, n_edges);
      $display("%0d visible cubes and %0d fully enclosed voxels seen", chk_drawn,
               chk_enclosed);
      if (chk_errors == 0 && chk_outstanding == 0) begin
         $display("voxel_face_visibility_core regression: pass");
      end else begin
         $display("voxel_face_visibility_core regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("voxel_face_visibility_core regression: fail");
      $finish;
   end

endmodule
